FILE: design/tnfr_pkg.sv
// Shared types and constants for the tone nibble frame receiver.
package tnfr_pkg;

  localparam int FRAME_DEPTH_DEFAULT = 16;
  localparam int CNT_W               = 5;
  localparam int NIB_W               = 4;
  localparam int SUM_W               = 4;
  localparam int IDLE_W              = 16;
  localparam int VOLT_W              = 15;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 16;
  localparam int MIN_LEN             = 6;
  localparam int VOLT_SCALE          = 100;

  localparam logic [NIB_W-1:0]  START_NIBBLE       = 4'hF;
  localparam logic [IDLE_W-1:0] TIMEOUT_RESET      = 16'd100;
  localparam logic [CNT_W-1:0]  FRAME_LENGTH_RESET = 5'd8;

  typedef enum logic {
    REQ_STROBE = 1'b0,
    REQ_TICK   = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STATUS_BAD_SUM  = 2'd0,
    STATUS_NO_MATCH = 2'd1,
    STATUS_READ     = 2'd2,
    STATUS_WRITE    = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OWN_TYPE      = 3'd0,
    REG_OWN_PLACE     = 3'd1,
    REG_OWN_NUMBER    = 3'd2,
    REG_TIMEOUT_TICKS = 3'd3,
    REG_FRAME_LENGTH  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [3:0] own_type;
    logic [2:0] own_place;
    logic [3:0] own_number;
  } identity_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [NIB_W-1:0] ctrl;
    logic [NIB_W-1:0] lamp_type;
    logic [NIB_W-1:0] lamp_number;
    logic [NIB_W-1:0] volt_lo;
    logic [NIB_W-1:0] volt_hi;
  } frame_fields_t;

  typedef struct packed {
    status_t           status;
    logic [VOLT_W-1:0] voltage;
    logic              changed;
  } check_result_t;

endpackage

FILE: design/tnfr_frame_check.sv
// Frame check: checksum, identity match and voltage load decision.
module tnfr_frame_check (
  input  tnfr_pkg::identity_t                 identity,
  input  tnfr_pkg::frame_fields_t             fields,
  input  logic [tnfr_pkg::VOLT_W-1:0]         stored_voltage,
  output tnfr_pkg::check_result_t             result
);
  import tnfr_pkg::*;

  logic [VOLT_W-1:0] new_voltage;
  logic              id_match;

  assign new_voltage = {7'b0, fields.volt_hi, fields.volt_lo} * VOLT_W'(VOLT_SCALE);
  assign id_match    = (identity.own_type == fields.lamp_type) &&
                       (identity.own_place == fields.ctrl[3:1]) &&
                       (identity.own_number == fields.lamp_number);

  always_comb begin
    result.status  = STATUS_READ;
    result.voltage = stored_voltage;
    result.changed = 1'b0;
    if (fields.sum != '0) begin
      result.status = STATUS_BAD_SUM;
    end else if (!id_match) begin
      result.status = STATUS_NO_MATCH;
    end else if (fields.ctrl[0]) begin
      result.status  = STATUS_WRITE;
      result.voltage = new_voltage;
      result.changed = (new_voltage != stored_voltage);
    end
  end

endmodule

FILE: design/tone_nibble_frame_receiver.sv
// Top level: nibble frame assembly, timeout, check and result register.
// A frame's check result is registered when its last nibble is accepted.
// Throughput: one transaction per cycle; input stalls only while a result is held by out_stall.
// Frame state updates in the accept cycle; the check is one short pass into the result register.
// Reset (rst, synchronous): count, sum, idle ticks, voltage and out_valid cleared; registers to their defaults.
// The frame store has no reset and is only read at entries written by the current frame.
module tone_nibble_frame_receiver #(
  parameter int FRAME_DEPTH = tnfr_pkg::FRAME_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tnfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tnfr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic [tnfr_pkg::NIB_W-1:0]         nibble,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         frame_status,
  output logic [tnfr_pkg::VOLT_W-1:0]        voltage_setting,
  output logic                               voltage_changed
);
  import tnfr_pkg::*;

  localparam int IDX_W = $clog2(FRAME_DEPTH);

  identity_t          identity;
  logic [IDLE_W-1:0]  timeout_ticks;
  logic [CNT_W-1:0]   frame_length;

  logic [CNT_W-1:0]   nibble_count, nibble_count_next;
  logic [SUM_W-1:0]   running_sum, running_sum_next;
  logic [IDLE_W-1:0]  idle_ticks, idle_ticks_next;
  logic [VOLT_W-1:0]  stored_voltage;
  logic [NIB_W-1:0]   frame_store [FRAME_DEPTH];

  logic               accept;
  logic               strobe;
  logic               start_ok;
  logic               store_en;
  logic               frame_done;
  logic [CNT_W-1:0]   eff_len;
  logic [CNT_W-1:0]   count_inc;
  logic [IDLE_W-1:0]  idle_inc;
  logic [SUM_W-1:0]   sum_new;
  logic [NIB_W-1:0]   nib_view [1:5];
  frame_fields_t      fields;
  check_result_t      chk;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign strobe   = (req_type == REQ_STROBE);
  assign start_ok = (nibble_count != '0) || (nibble == START_NIBBLE);
  assign store_en = accept & strobe & start_ok & (nibble_count < CNT_W'(FRAME_DEPTH));

  assign count_inc = (nibble_count == '1) ? nibble_count : nibble_count + 1'b1;
  assign idle_inc  = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;
  assign sum_new   = ((nibble_count == '0) ? '0 : running_sum) + nibble;

  always_comb begin
    if (frame_length < CNT_W'(MIN_LEN)) begin
      eff_len = CNT_W'(MIN_LEN);
    end else if (frame_length > CNT_W'(FRAME_DEPTH)) begin
      eff_len = CNT_W'(FRAME_DEPTH);
    end else begin
      eff_len = frame_length;
    end
  end

  always_comb begin
    nibble_count_next = nibble_count;
    running_sum_next  = running_sum;
    idle_ticks_next   = idle_ticks;
    frame_done        = 1'b0;
    if (accept) begin
      if (!strobe) begin
        if (nibble_count != '0) begin
          idle_ticks_next = idle_inc;
          if (idle_inc >= timeout_ticks) begin
            nibble_count_next = '0;
            idle_ticks_next   = '0;
          end
        end
      end else begin
        idle_ticks_next = '0;
        if (start_ok) begin
          running_sum_next  = sum_new;
          nibble_count_next = count_inc;
          if (count_inc >= eff_len) begin
            frame_done        = 1'b1;
            nibble_count_next = '0;
          end
        end
      end
    end
  end

  // current nibble bypasses the store when it lands in a checked entry
  always_comb begin
    for (int i = 1; i <= 5; i++) begin
      nib_view[i] = (nibble_count == CNT_W'(i)) ? nibble : frame_store[i];
    end
  end

  assign fields.sum         = sum_new;
  assign fields.ctrl        = nib_view[1];
  assign fields.lamp_type   = nib_view[2];
  assign fields.lamp_number = nib_view[3];
  assign fields.volt_lo     = nib_view[4];
  assign fields.volt_hi     = nib_view[5];

  tnfr_frame_check u_check (
    .identity       (identity),
    .fields         (fields),
    .stored_voltage (stored_voltage),
    .result         (chk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      identity       <= '0;
      timeout_ticks  <= TIMEOUT_RESET;
      frame_length   <= FRAME_LENGTH_RESET;
      nibble_count   <= '0;
      running_sum    <= '0;
      idle_ticks     <= '0;
      stored_voltage <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_OWN_TYPE:      identity.own_type   <= cfg_data[3:0];
          REG_OWN_PLACE:     identity.own_place  <= cfg_data[2:0];
          REG_OWN_NUMBER:    identity.own_number <= cfg_data[3:0];
          REG_TIMEOUT_TICKS: timeout_ticks       <= cfg_data;
          REG_FRAME_LENGTH:  frame_length        <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      nibble_count <= nibble_count_next;
      running_sum  <= running_sum_next;
      idle_ticks   <= idle_ticks_next;
      if (frame_done) begin
        stored_voltage <= chk.voltage;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_store[nibble_count[IDX_W-1:0]] <= nibble;
    end
    if (frame_done) begin
      frame_status    <= chk.status;
      voltage_setting <= chk.voltage;
      voltage_changed <= chk.changed;
    end
  end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the tone nibble frame receiver.
module testbench;
  import tnfr_pkg::*;

  typedef struct {
    req_t       kind;
    logic [3:0] nib;
  } tone_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [3:0]  nibble = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  frame_status;
  logic [14:0] voltage_setting;
  logic        voltage_changed;

  tone_nibble_frame_receiver dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .nibble(nibble),
    .out_valid(out_valid), .out_stall(out_stall), .frame_status(frame_status),
    .voltage_setting(voltage_setting), .voltage_changed(voltage_changed)
  );

  always #5 clk = ~clk;

  // register shadows
  logic [3:0]  unit_type = 4'd0;
  logic [2:0]  unit_place = 3'd0;
  logic [3:0]  unit_number = 4'd0;
  logic [15:0] drop_ticks = TIMEOUT_RESET;
  logic [4:0]  span_reg = FRAME_LENGTH_RESET;

  // frame state of the receiver as predicted
  logic [4:0]  held_count = '0;
  logic [3:0]  held_sum = '0;
  logic [3:0]  held_nibs [FRAME_DEPTH_DEFAULT];
  logic [15:0] idle_run = '0;
  logic [14:0] volt_now = '0;

  tone_t         pending_tones [$];
  check_result_t awaited_reports [$];
  logic [3:0]    draft [$];
  tone_t         shown;
  check_result_t oldest;
  bit            sending = 1'b0;
  bit            calm = 1'b0;
  int unsigned   idle_odds = 0;
  int unsigned   send_gap = 0;
  int unsigned   recv_gap = 0;
  int unsigned   fails = 0;
  int unsigned   queued = 0;
  logic [7:0]    last_volt = '0;

  function automatic int unsigned frame_span();
    int unsigned n;
    n = span_reg;
    if (n < MIN_LEN) n = MIN_LEN;
    if (n > FRAME_DEPTH_DEFAULT) n = FRAME_DEPTH_DEFAULT;
    return n;
  endfunction

  task automatic track_tone(input req_t kind, input logic [3:0] nib);
    check_result_t rep;
    int unsigned   scaled;
    if (kind == REQ_TICK) begin
      if (held_count != 0) begin
        if (idle_run != 16'hFFFF) idle_run++;
        if (idle_run >= drop_ticks) begin
          held_count = '0;
          idle_run = '0;
        end
      end
      return;
    end
    idle_run = '0;
    if (held_count == 0) begin
      if (nib != START_NIBBLE) return;
      held_sum = '0;
    end
    held_sum = held_sum + nib;
    if (held_count < FRAME_DEPTH_DEFAULT) held_nibs[held_count[3:0]] = nib;
    if (held_count < 31) held_count++;
    if (held_count >= frame_span()) begin
      rep.changed = 1'b0;
      if (held_sum != 0) begin
        rep.status = STATUS_BAD_SUM;
      end else if (unit_type != held_nibs[2] || unit_place != held_nibs[1][3:1] ||
                   unit_number != held_nibs[3]) begin
        rep.status = STATUS_NO_MATCH;
      end else if (held_nibs[1][0]) begin
        rep.status = STATUS_WRITE;
        scaled = {held_nibs[5], held_nibs[4]} * VOLT_SCALE;
        if (15'(scaled) != volt_now) begin
          volt_now = 15'(scaled);
          rep.changed = 1'b1;
        end
      end else begin
        rep.status = STATUS_READ;
      end
      rep.voltage = volt_now;
      awaited_reports.push_back(rep);
      held_count = '0;
      idle_run = '0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      sending = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_tone(shown.kind, shown.nib);
        sending = 1'b0;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_tones.size() != 0 && !calm && idle_odds != 0 &&
                     $urandom_range(1, idle_odds) == 1) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pending_tones.size() != 0) begin
          shown = pending_tones.pop_front();
          req_type <= shown.kind;
          nibble <= shown.nib;
          in_valid <= 1'b1;
          sending = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("frame_status: no transaction expected, actual %0d", frame_status);
          fails++;
        end else begin
          oldest = awaited_reports.pop_front();
          if (frame_status !== oldest.status) begin
            $error("frame_status expected %0d actual %0d", oldest.status, frame_status);
            fails++;
          end
          if (voltage_setting !== oldest.voltage) begin
            $error("voltage_setting expected %0d actual %0d", oldest.voltage, voltage_setting);
            fails++;
          end
          if (voltage_changed !== oldest.changed) begin
            $error("voltage_changed expected %0d actual %0d", oldest.changed, voltage_changed);
            fails++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        recv_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_tone(input req_t kind, input logic [3:0] nib);
    tone_t t;
    t.kind = kind;
    t.nib = nib;
    pending_tones.push_back(t);
    queued++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] ty, input logic [2:0] pl,
                              input logic [3:0] num, input logic [15:0] tmo,
                              input logic [4:0] len);
    write_reg(REG_OWN_TYPE, 16'(ty));
    write_reg(REG_OWN_PLACE, 16'(pl));
    write_reg(REG_OWN_NUMBER, 16'(num));
    write_reg(REG_TIMEOUT_TICKS, tmo);
    write_reg(REG_FRAME_LENGTH, 16'(len));
    cfg_write <= 1'b0;
    unit_type = ty;
    unit_place = pl;
    unit_number = num;
    drop_ticks = tmo;
    span_reg = len;
  endtask

  // all transactions delivered and answered, then waits out in-flight work
  task automatic settle();
    do @(posedge clk);
    while (pending_tones.size() != 0 || sending || awaited_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // builds one frame at the current length; last nibble fixes or breaks the checksum
  task automatic compose_frame(input bit wr, input logic [3:0] ty, input logic [2:0] pl,
                               input logic [3:0] num, input logic [7:0] volt,
                               input bit sum_ok);
    int unsigned len;
    logic [3:0]  total;
    len = frame_span();
    draft.delete();
    draft.push_back(START_NIBBLE);
    draft.push_back({pl, wr});
    draft.push_back(ty);
    draft.push_back(num);
    draft.push_back(volt[3:0]);
    draft.push_back(volt[7:4]);
    while (draft.size() < len) draft.push_back(4'($urandom));
    total = '0;
    foreach (draft[i]) total = total + draft[i];
    if (sum_ok) draft[len-1] = draft[len-1] - total;
    else if (total == 0) draft[len-1] = draft[len-1] + 4'($urandom_range(1, 15));
  endtask

  task automatic compose_random(input bit addressed);
    logic [3:0] ty;
    logic [2:0] pl;
    logic [3:0] num;
    logic [7:0] v;
    ty = unit_type;
    pl = unit_place;
    num = unit_number;
    if (!addressed) begin
      case ($urandom_range(0, 2))
        0: ty = ty ^ 4'($urandom_range(1, 15));
        1: pl = pl ^ 3'($urandom_range(1, 7));
        default: num = num ^ 4'($urandom_range(1, 15));
      endcase
    end
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = last_volt;
      default: v = 8'($urandom);
    endcase
    last_volt = v;
    compose_frame(1'($urandom_range(0, 1)), ty, pl, num, v, $urandom_range(0, 7) != 0);
  endtask

  // ticks between nibbles stay below the timeout so the frame survives
  task automatic send_draft(input int unsigned odds);
    int unsigned k;
    foreach (draft[i]) begin
      if (i > 0 && odds != 0 && drop_ticks > 1 && $urandom_range(1, odds) == 1) begin
        k = $urandom_range(1, (drop_ticks > 13) ? 12 : drop_ticks - 1);
        repeat (k) queue_tone(REQ_TICK, 4'($urandom));
      end
      queue_tone(REQ_STROBE, draft[i]);
    end
  endtask

  task automatic run_mix(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned k;
    start = queued;
    while (queued - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        compose_random($urandom_range(0, 3) != 0);
        send_draft(6);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) queue_tone(req_t'($urandom_range(0, 1)), 4'($urandom));
      end else begin
        // truncated frame, often followed by enough ticks to drop it
        compose_random(1'b1);
        k = $urandom_range(1, draft.size() - 1);
        for (int i = 0; i < k; i++) queue_tone(REQ_STROBE, draft[i]);
        if (drop_ticks <= 150 && $urandom_range(0, 1) == 1)
          repeat ((drop_ticks == 0) ? 1 : drop_ticks) queue_tone(REQ_TICK, 4'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    queue_tone(REQ_TICK, START_NIBBLE);
    queue_tone(REQ_STROBE, 4'h0);
    compose_frame(1'b1, 4'h0, 3'h0, 4'h0, 8'hFF, 1'b1);
    send_draft(0);
    compose_frame(1'b0, 4'h0, 3'h0, 4'h0, 8'h00, 1'b0);
    send_draft(0);
    compose_frame(1'b0, 4'hF, 3'h7, 4'hF, 8'h5A, 1'b1);
    send_draft(0);
    settle();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: program_regs(4'hF, 3'h7, 4'hF, 16'd1, 5'd6);
        1: program_regs(4'h0, 3'h0, 4'h0, 16'hFFFF, 5'd16);
        2: program_regs(4'($urandom), 3'($urandom), 4'($urandom), 16'd0, 5'd5);
        3: program_regs(4'($urandom), 3'($urandom), 4'($urandom), 16'd2, 5'd17);
        4: program_regs(4'($urandom), 3'($urandom), 4'($urandom), 16'd3, 5'd31);
        5: program_regs(4'($urandom), 3'($urandom), 4'($urandom), 16'd100, 5'd0);
        default: program_regs(4'($urandom), 3'($urandom), 4'($urandom),
                              16'($urandom_range(1, 40)), 5'($urandom_range(0, 31)));
      endcase
      idle_odds = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 6 : 20);
      run_mix(60);
      settle();
    end

    // long timeout: one tick short survives, a full count drops the frame
    idle_odds = 20;
    program_regs(4'($urandom), 3'($urandom), 4'($urandom), 16'd60, 5'd6);
    compose_random(1'b1);
    for (int i = 0; i < 3; i++) queue_tone(REQ_STROBE, draft[i]);
    repeat (59) queue_tone(REQ_TICK, 4'($urandom));
    for (int i = 3; i < draft.size(); i++) queue_tone(REQ_STROBE, draft[i]);
    compose_random(1'b1);
    for (int i = 0; i < 3; i++) queue_tone(REQ_STROBE, draft[i]);
    repeat (60) queue_tone(REQ_TICK, 4'($urandom));
    compose_random(1'b1);
    send_draft(0);
    settle();

    calm = 1'b1;
    program_regs(4'($urandom), 3'($urandom), 4'($urandom),
                 16'($urandom_range(1, 40)), 5'($urandom_range(0, 31)));
    run_mix(90);
    settle();

    if (fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
